// ===== sv/sv39pte_pkg.sv =====
// Package for the Sv39 page-table engine: sequencer states, request and
// status codes, and page-table entry constants. No dependencies.
package sv39pte_pkg;

  localparam int unsigned TableFramesDef = 16;
  localparam int unsigned EntPerTbl      = 512;

  // Request kinds.
  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_RANGE = 2'd1;
  localparam logic [1:0] REQ_UNMAP = 2'd2;
  localparam logic [1:0] REQ_PROBE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TABLE = 2'd1;
  localparam logic [1:0] ST_COVERED  = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  // Entry flag bits that every new leaf carries: V, A and D.
  localparam logic [7:0] LeafFixed = 8'hC1;

  // Step sizes of a range map, 4 KiB and 2 MiB.
  localparam logic [55:0] StepSmall = 56'h1000;
  localparam logic [55:0] StepMega  = 56'h20_0000;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_ZERO,
    S_DONE
  } state_e;

  // What the evaluation of one read entry decides.
  typedef enum logic [1:0] {
    ACT_DESCEND,
    ACT_ALLOC,
    ACT_FINISH,
    ACT_NEXT
  } act_e;

endpackage

// ===== sv/sv39_page_table_engine_unit.sv =====
// Top level of the Sv39 page-table engine: table store memory, walk
// sequencer, frame allocator and result register. Uses sv39pte_pkg.
//
// Channel   Dir  Handshake               Carries
// in        in   in_valid_i / in_stall_o  req_type, vaddr, paddr, leaf_flags,
//                                         map_level, page_count
// out       out  out_valid_o / out_stall_i status, translated_addr
// cfg       in   cfg_valid_i / cfg_ready_o table_base_ppn
//
// Each table level takes a memory read (S_RD), then evaluate and write back
// (S_EVAL). A walk ends in S_DONE, and the next item is accepted only once
// the result is in the output register and the sequencer is back in S_IDLE.
// A range map repeats the walk from the top for each page, down three levels
// for a 4 KiB page and two for a 2 MiB page. Each new table frame adds a
// zeroing sweep of its 512 entries through the single memory port. After
// reset the whole store (TABLE_FRAMES*512 entries) is cleared, and no item
// is accepted meanwhile. A stalled result waits in the output register.
module sv39_page_table_engine_unit #(
  parameter int unsigned TABLE_FRAMES = sv39pte_pkg::TableFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [43:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [38:0] vaddr_i,
  input  logic [55:0] paddr_i,
  input  logic [7:0]  leaf_flags_i,
  input  logic        map_level_i,
  input  logic [15:0] page_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [55:0] translated_addr_o
);
  import sv39pte_pkg::*;

  localparam int unsigned FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int unsigned UW    = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned AW    = FW + 9;
  localparam int unsigned Depth = TABLE_FRAMES * EntPerTbl;

  // Control registers.
  state_e          state_q, state_d;
  logic [UW-1:0]   fu_q, fu_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [43:0]     base_q;
  logic            out_valid_q;

  // Payload registers.
  logic [1:0]      req_q, req_d;
  logic [38:0]     va_q, va_d;
  logic [55:0]     pa_q, pa_d;
  logic [7:0]      flags_q, flags_d;
  logic            lvl_q, lvl_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [15:0]     k_q, k_d;
  logic [1:0]      lev_q, lev_d;
  logic [FW-1:0]   frame_q, frame_d;
  logic [1:0]      st_q, st_d;
  logic [55:0]     xaddr_q, xaddr_d;
  logic [1:0]      out_status_q;
  logic [55:0]     out_addr_q;

  // Memory.
  logic [63:0]     store_mem [Depth];
  logic [63:0]     rdata_q;
  logic            mem_re;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [63:0]     mem_wdata;

  // Evaluation of the read entry.
  logic            in_acc;
  logic            out_load;
  logic [8:0]      ix;
  logic [AW-1:0]   ent_addr;
  logic            e_v;
  logic            e_leaf;
  logic [43:0]     e_d;
  logic            e_inpool;
  logic            at_target;
  logic            pool_full;
  logic [55:0]     xlate;
  logic [55:0]     va_off;
  logic [63:0]     leaf_ent;
  logic [63:0]     ptr_ent;
  logic [43:0]     ptr_ppn;
  act_e            act;
  logic [1:0]      act_st;
  logic            act_wr;
  logic [55:0]     step;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign translated_addr_o = out_addr_q;

  // Table index of the current level.
  always_comb begin
    case (lev_q)
      2'd2:    ix = va_q[38:30];
      2'd1:    ix = va_q[29:21];
      default: ix = va_q[20:12];
    endcase
  end
  assign ent_addr = {frame_q, ix};

  // Decode of the entry read at this level.
  assign e_v       = rdata_q[0];
  assign e_leaf    = |rdata_q[3:1];
  assign e_d       = rdata_q[53:10] - base_q;
  assign e_inpool  = (e_d < 44'(TABLE_FRAMES));
  assign at_target = (lev_q == ((req_q == REQ_RANGE) ? {1'b0, lvl_q} : 2'd0));
  assign pool_full = (fu_q >= UW'(TABLE_FRAMES));
  assign ptr_ppn   = base_q + 44'(fu_q);
  assign ptr_ent   = {10'b0, ptr_ppn, 9'b0, 1'b1};
  assign leaf_ent  = {10'b0, pa_q[55:12], 2'b0, flags_q | LeafFixed};
  assign step      = lvl_q ? StepMega : StepSmall;

  // Probe translation: leaf page plus the offset bits below that level.
  always_comb begin
    case (lev_q)
      2'd2:    va_off = {26'b0, va_q[29:0]};
      2'd1:    va_off = {35'b0, va_q[20:0]};
      default: va_off = {44'b0, va_q[11:0]};
    endcase
  end
  assign xlate = {rdata_q[53:10], 12'b0} + va_off;

  // Action for the entry under evaluation.
  always_comb begin
    act    = ACT_FINISH;
    act_st = ST_OK;
    act_wr = 1'b0;
    if (req_q == REQ_PROBE) begin
      if (!e_v) begin
        act_st = ST_UNMAPPED;
      end else if (e_leaf) begin
        act_st = ST_OK;
      end else if ((lev_q == 2'd0) || !e_inpool) begin
        act_st = ST_UNMAPPED;
      end else begin
        act = ACT_DESCEND;
      end
    end else if (!at_target) begin
      if (!e_v) begin
        if (req_q == REQ_UNMAP) begin
          act_st = ST_UNMAPPED;
        end else if (pool_full) begin
          act_st = ST_NO_TABLE;
        end else begin
          act    = ACT_ALLOC;
          act_wr = 1'b1;
        end
      end else if (e_leaf || !e_inpool) begin
        act_st = (req_q == REQ_UNMAP) ? ST_UNMAPPED : ST_COVERED;
      end else begin
        act = ACT_DESCEND;
      end
    end else begin
      case (req_q)
        REQ_MAP: begin
          act_wr = 1'b1;
        end
        REQ_UNMAP: begin
          act_wr = e_v;
          act_st = e_v ? ST_OK : ST_UNMAPPED;
        end
        default: begin
          act_wr = !e_v;
          act    = (16'(k_q + 16'd1) == cnt_q) ? ACT_FINISH : ACT_NEXT;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = ((req_type_i == REQ_RANGE) && (page_count_i == 16'd0)) ? S_DONE : S_RD;
        end
      end
      S_RD: state_d = S_EVAL;
      S_EVAL: begin
        case (act)
          ACT_ALLOC:  state_d = S_ZERO;
          ACT_FINISH: state_d = S_DONE;
          default:    state_d = S_RD;
        endcase
      end
      S_ZERO: begin
        if (clr_q[8:0] == 9'h1FF) state_d = S_RD;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    fu_d      = fu_q;
    clr_d     = clr_q;
    req_d     = req_q;
    va_d      = va_q;
    pa_d      = pa_q;
    flags_d   = flags_q;
    lvl_d     = lvl_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    lev_d     = lev_q;
    frame_d   = frame_q;
    st_d      = st_q;
    xaddr_d   = xaddr_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ent_addr;
    mem_wdata = leaf_ent;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 64'b0;
        clr_d     = clr_q + AW'(1);
      end
      S_IDLE: begin
        req_d   = req_type_i;
        va_d    = vaddr_i;
        pa_d    = paddr_i;
        flags_d = leaf_flags_i;
        lvl_d   = map_level_i;
        cnt_d   = page_count_i;
        k_d     = 16'd0;
        lev_d   = 2'd2;
        frame_d = '0;
        st_d    = ST_OK;
        xaddr_d = '0;
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_EVAL: begin
        mem_we    = act_wr;
        mem_wdata = (act == ACT_ALLOC) ? ptr_ent :
                    (req_q == REQ_UNMAP) ? 64'b0 : leaf_ent;
        case (act)
          ACT_DESCEND: begin
            frame_d = e_d[FW-1:0];
            lev_d   = lev_q - 2'd1;
          end
          ACT_ALLOC: begin
            frame_d = fu_q[FW-1:0];
            fu_d    = fu_q + UW'(1);
            lev_d   = lev_q - 2'd1;
            clr_d   = '0;
          end
          ACT_NEXT: begin
            k_d     = k_q + 16'd1;
            va_d    = va_q + step[38:0];
            pa_d    = pa_q + step;
            lev_d   = 2'd2;
            frame_d = '0;
          end
          default: begin
            st_d    = act_st;
            xaddr_d = ((req_q == REQ_PROBE) && (act_st == ST_OK)) ? xlate : 56'b0;
          end
        endcase
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_addr  = {frame_q, clr_q[8:0]};
        mem_wdata = 64'b0;
        clr_d     = clr_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Table store: one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= store_mem[mem_addr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fu_q        <= UW'(1);
      clr_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fu_q    <= fu_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) base_q <= cfg_data_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    va_q    <= va_d;
    pa_q    <= pa_d;
    flags_q <= flags_d;
    lvl_q   <= lvl_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    lev_q   <= lev_d;
    frame_q <= frame_d;
    st_q    <= st_d;
    xaddr_q <= xaddr_d;
    if (out_load) begin
      out_status_q <= st_q;
      out_addr_q   <= xaddr_q;
    end
  end

  // The allocator never goes beyond the pool and never gives frames back.
  a_fu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fu_q >= UW'(1)) && (fu_q <= UW'(TABLE_FRAMES)))
    else $error("frame count out of range");

  a_fu_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fu_q >= $past(fu_q))
    else $error("frame count decreased");

  // The store is never written while the block waits for an item.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RD) || (state_q == S_DONE))
    else $error("accepted item not started");

endmodule
